// ----- sv/hsv_to_rgb_converter_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define HSV2RGB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define HSV2RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

  localparam int unsigned HUE_BITS_DEF     = 16;
  localparam int unsigned CHANNEL_BITS_DEF = 8;

  // Register stages between the input and the output port.
  localparam int unsigned PIPE_DEPTH = 4;

  localparam int unsigned SECTOR_BITS = 3;

  // Hue sectors, floor(6h).
  typedef enum logic [SECTOR_BITS-1:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

endpackage

// ----- sv/hsv2rgb_if.sv -----
interface hsv_pixel_if #(
  parameter int unsigned HUE_BITS     = 16,
  parameter int unsigned CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface rgb_pixel_if #(
  parameter int unsigned CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- sv/hsv_to_rgb_converter.sv -----
// HSV to RGB pixel converter, six-sector rule.
// hsv_i takes one pixel per transaction: hue (fraction of a turn), saturation
// and brightness (all-ones = 1.0). rgb_o gives one pixel per transaction with
// red, green and blue truncated toward zero.
// Throughput: one pixel per clock while rgb_o.ready is high. The result passes
// through four register stages: hue*6 and v(1-s); f*s and (1-f)*s; v*(1-fs)
// and v*(1-(1-f)s); the divide by the channel maximum and the sector mux.
// Each stage carries its own valid bit. When rgb_o.ready is low the output
// holds; earlier stages keep filling empty slots, so hsv_i.ready only drops
// once every stage holds a pixel. Nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) empties all stages; rgb_o.valid goes low
// and hsv_i.ready is high out of reset.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
  parameter int unsigned HUE_BITS     = HUE_BITS_DEF,
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  hsv_pixel_if.sink          hsv_i,
  rgb_pixel_if.source        rgb_o
);

  localparam int unsigned H = HUE_BITS;
  localparam int unsigned C = CHANNEL_BITS;
  localparam logic [C-1:0] ChMax = '1;

  // floor(x / (2^C - 1)), exact for x <= (2^C - 1)^2
  function automatic logic [C-1:0] div_max(input logic [2*C-1:0] x);
    logic [2*C:0] y;
    y = {1'b0, x} + {{(C+1){1'b0}}, x[2*C-1:C]} + {{(2*C){1'b0}}, 1'b1};
    return y[2*C-1:C];
  endfunction

  logic [PIPE_DEPTH-1:0] vld_q, vld_d, en;

  // handshake: a stage loads when empty or when its content moves on
  always_comb begin
    en[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || rgb_o.ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? hsv_i.valid : vld_q[0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign hsv_i.ready = en[0];

  // stage 1: sector, fraction, v*(M-s)
  logic [H+2:0]   six;
  sector_e        sec1_d, sec1_q;
  logic [H-1:0]   frac1_q;
  logic [C-1:0]   sat1_q, val1_q;
  logic [2*C-1:0] pprod1_d, pprod1_q;

  assign six      = ({3'b000, hsv_i.hue} << 2) + ({3'b000, hsv_i.hue} << 1);
  assign sec1_d   = sector_e'(six[H+2:H]);
  assign pprod1_d = {{C{1'b0}}, hsv_i.brightness} * {{C{1'b0}}, ~hsv_i.saturation};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sec1_q   <= sec1_d;
      frac1_q  <= six[H-1:0];
      sat1_q   <= hsv_i.saturation;
      val1_q   <= hsv_i.brightness;
      pprod1_q <= pprod1_d;
    end
  end

  // stage 2: f*s, (1-f)*s, p code
  logic [H:0]     frac_inv;
  logic [H+C:0]   fs2_d, gs2_d, fs2_q, gs2_q;
  sector_e        sec2_q;
  logic [C-1:0]   val2_q, p2_q;

  assign frac_inv = {1'b1, {H{1'b0}}} - {1'b0, frac1_q};
  assign fs2_d    = {{(C+1){1'b0}}, frac1_q} * {{(H+1){1'b0}}, sat1_q};
  assign gs2_d    = {{C{1'b0}}, frac_inv} * {{(H+1){1'b0}}, sat1_q};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sec2_q <= sec1_q;
      val2_q <= val1_q;
      fs2_q  <= fs2_d;
      gs2_q  <= gs2_d;
      p2_q   <= div_max(pprod1_q);
    end
  end

  // stage 3: v*(D - f*s) and v*(D - (1-f)*s), scaled down by 2^H
  localparam logic [H+C:0] Den = {1'b0, ChMax, {H{1'b0}}};
  logic [H+C:0]     qa, ta;
  logic [2*C+H-1:0] qprod, tprod;
  sector_e          sec3_q;
  logic [C-1:0]     val3_q, p3_q;
  logic [2*C-1:0]   qx3_q, tx3_q;

  assign qa    = Den - fs2_q;
  assign ta    = Den - gs2_q;
  assign qprod = {{C{1'b0}}, qa[H+C-1:0]} * {{(C+H){1'b0}}, val2_q};
  assign tprod = {{C{1'b0}}, ta[H+C-1:0]} * {{(C+H){1'b0}}, val2_q};

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sec3_q <= sec2_q;
      val3_q <= val2_q;
      p3_q   <= p2_q;
      qx3_q  <= qprod[2*C+H-1:H];
      tx3_q  <= tprod[2*C+H-1:H];
    end
  end

  // stage 4: q and t codes, sector routing
  logic [C-1:0] q4, t4;
  logic [C-1:0] red_d, green_d, blue_d;
  logic [C-1:0] red_q, green_q, blue_q;

  assign q4 = div_max(qx3_q);
  assign t4 = div_max(tx3_q);

  always_comb begin
    case (sec3_q)
      SEC_RED: begin
        red_d = val3_q; green_d = t4;     blue_d = p3_q;
      end
      SEC_YELLOW: begin
        red_d = q4;     green_d = val3_q; blue_d = p3_q;
      end
      SEC_GREEN: begin
        red_d = p3_q;   green_d = val3_q; blue_d = t4;
      end
      SEC_CYAN: begin
        red_d = p3_q;   green_d = q4;     blue_d = val3_q;
      end
      SEC_BLUE: begin
        red_d = t4;     green_d = p3_q;   blue_d = val3_q;
      end
      default: begin
        red_d = val3_q; green_d = p3_q;   blue_d = q4;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign rgb_o.valid = vld_q[PIPE_DEPTH-1];
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

endmodule

// ----- sv/hsv2rgb_checker.sv -----
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_checker import hsv2rgb_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [CHANNEL_BITS-1:0] red_i,
  input logic [CHANNEL_BITS-1:0] green_i,
  input logic [CHANNEL_BITS-1:0] blue_i
);

  localparam int unsigned CntW = $clog2(PIPE_DEPTH + 1);

  // pixels accepted but not yet delivered
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `HSV2RGB_ASSERT_NEXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i, "rgb valid dropped while stalled")
  `HSV2RGB_ASSERT_NEXT(a_out_data_hold, out_valid_i && !out_ready_i, $stable(red_i) && $stable(green_i) && $stable(blue_i), "rgb payload changed while stalled")
  `HSV2RGB_ASSERT_IMPL(a_no_phantom, out_valid_i, cnt_q != '0, "rgb transaction without a pending hsv transaction")
  `HSV2RGB_ASSERT_IMPL(a_depth, 1'b1, cnt_q <= CntW'(PIPE_DEPTH), "more pixels in flight than pipeline stages")
  `HSV2RGB_ASSERT_IMPL(a_ready_flow, out_ready_i, in_ready_i, "input stalled although output drains")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker #(
  .CHANNEL_BITS(CHANNEL_BITS)
) u_hsv2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hsv_i.valid),
  .in_ready_i  (hsv_i.ready),
  .out_valid_i (rgb_o.valid),
  .out_ready_i (rgb_o.ready),
  .red_i       (rgb_o.red),
  .green_i     (rgb_o.green),
  .blue_i      (rgb_o.blue)
);
